@@ rtl/uidfs_pkg.sv @@
package uidfs_pkg;

    // Longest string kept; bytes beyond it are dropped and flagged
    localparam int MAX_LEN = 256;
    // Position and depth counters must hold MAX_LEN itself
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    // Output span fields are fixed at 9 bits
    localparam int SPAN_W  = 9;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Part codes, also the order of the results
    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_EMAIL   = 2'd1,
        KIND_COMMENT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
    } t_span;

    // Everything reported for one string
    typedef struct packed {
        t_span name;
        t_span email;
        t_span comment;
        logic  overflow;
    } t_span_set;

    // Trim whitespace: tab, LF, VT, FF, CR and space
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ rtl/uidfs_parser.sv @@
module uidfs_parser import uidfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_character,
    input  logic       i_end_of_string,
    output t_span_set  o_spans
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_inside, n_inside;
    logic [POS_W-1:0] r_email_depth, n_email_depth;
    logic [POS_W-1:0] r_comment_depth, n_comment_depth;
    logic [POS_W-1:0] r_first, n_first;
    logic [POS_W-1:0] r_last, n_last;
    logic             r_seen, n_seen;
    logic [2:0]       r_valid, n_valid;
    t_span            r_span [3];
    t_span            n_span [3];
    logic             r_exceeded, n_exceeded;

    t_span            tail_span;
    logic             moved;

    // Span from the tail, already trimmed
    always_comb begin
        if (r_seen) begin
            tail_span.start  = r_first;
            tail_span.length = r_last - r_first + POS_W'(1);
        end else begin
            tail_span.start  = '0;
            tail_span.length = '0;
        end
    end

    // Per-byte parse and end-of-string clear
    always_comb begin
        n_pos           = r_pos;
        n_inside        = r_inside;
        n_email_depth   = r_email_depth;
        n_comment_depth = r_comment_depth;
        n_first         = r_first;
        n_last          = r_last;
        n_seen          = r_seen;
        n_valid         = r_valid;
        n_span          = r_span;
        n_exceeded      = r_exceeded;
        moved           = 1'b0;

        if (i_take && i_end_of_string) begin
            n_pos           = '0;
            n_inside        = 1'b0;
            n_email_depth   = '0;
            n_comment_depth = '0;
            n_first         = '0;
            n_last          = '0;
            n_seen          = 1'b0;
            n_valid         = '0;
            n_exceeded      = 1'b0;
            for (int k = 0; k < 3; k++) begin
                n_span[k] = '0;
            end
        end else if (i_take && (i_character != CH_NUL)) begin
            if (r_pos >= POS_W'(MAX_LEN)) begin
                n_exceeded = 1'b1;
            end else begin
                if (r_email_depth != '0) begin
                    if (i_character == CH_LT) begin
                        n_email_depth = r_email_depth + POS_W'(1);
                    end else if (i_character == CH_GT) begin
                        n_email_depth = r_email_depth - POS_W'(1);
                        if ((r_email_depth == POS_W'(1)) && !r_valid[KIND_EMAIL]) begin
                            n_valid[KIND_EMAIL] = 1'b1;
                            n_span[KIND_EMAIL]  = tail_span;
                            moved               = 1'b1;
                        end
                    end
                end else if (r_comment_depth != '0) begin
                    if (i_character == CH_LPAR) begin
                        n_comment_depth = r_comment_depth + POS_W'(1);
                    end else if (i_character == CH_RPAR) begin
                        n_comment_depth = r_comment_depth - POS_W'(1);
                        if ((r_comment_depth == POS_W'(1)) && !r_valid[KIND_COMMENT]) begin
                            n_valid[KIND_COMMENT] = 1'b1;
                            n_span[KIND_COMMENT]  = tail_span;
                            moved                 = 1'b1;
                        end
                    end
                end else if (i_character == CH_LT) begin
                    if (r_inside) begin
                        if (!r_valid[KIND_NAME]) begin
                            n_valid[KIND_NAME] = 1'b1;
                            n_span[KIND_NAME]  = tail_span;
                            moved              = 1'b1;
                        end
                        n_inside = 1'b0;
                    end else begin
                        moved = 1'b1;
                    end
                    n_email_depth = POS_W'(1);
                end else if (i_character == CH_LPAR) begin
                    if (r_inside) begin
                        if (!r_valid[KIND_NAME]) begin
                            n_valid[KIND_NAME] = 1'b1;
                            n_span[KIND_NAME]  = tail_span;
                            moved              = 1'b1;
                        end
                        n_inside = 1'b0;
                    end
                    n_comment_depth = POS_W'(1);
                end else if (!r_inside && (i_character != CH_SPACE)
                             && (i_character != CH_TAB)) begin
                    n_inside = 1'b1;
                end

                // Tail tracking: a capture restarts it
                if (moved) begin
                    n_seen  = 1'b0;
                    n_first = '0;
                    n_last  = '0;
                end else if (!is_blank(i_character)) begin
                    if (!r_seen) begin
                        n_seen  = 1'b1;
                        n_first = r_pos;
                    end
                    n_last = r_pos;
                end
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // Spans as seen by an end marker now; an open name runs to the end
    always_comb begin
        o_spans.name     = r_valid[KIND_NAME]    ? r_span[KIND_NAME]
                         : (r_inside ? tail_span : '0);
        o_spans.email    = r_valid[KIND_EMAIL]   ? r_span[KIND_EMAIL]   : '0;
        o_spans.comment  = r_valid[KIND_COMMENT] ? r_span[KIND_COMMENT] : '0;
        o_spans.overflow = r_exceeded;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos           <= '0;
            r_inside        <= 1'b0;
            r_email_depth   <= '0;
            r_comment_depth <= '0;
            r_first         <= '0;
            r_last          <= '0;
            r_seen          <= 1'b0;
            r_valid         <= '0;
            r_exceeded      <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_span[k] <= '0;
            end
        end else begin
            r_pos           <= n_pos;
            r_inside        <= n_inside;
            r_email_depth   <= n_email_depth;
            r_comment_depth <= n_comment_depth;
            r_first         <= n_first;
            r_last          <= n_last;
            r_seen          <= n_seen;
            r_valid         <= n_valid;
            r_exceeded      <= n_exceeded;
            r_span          <= n_span;
        end
    end

endmodule

@@ rtl/uidfs_emitter.sv @@
module uidfs_emitter import uidfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_span_set         i_spans,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_field_kind,
    output logic [SPAN_W-1:0] o_span_start,
    output logic [SPAN_W-1:0] o_span_length,
    output logic              o_overflow,
    output logic              o_last_result
);

    logic      r_busy, n_busy;
    t_kind     r_kind, n_kind;
    t_span_set r_set, n_set;
    t_span     cur;
    logic      out_take;
    logic      at_last;

    assign out_take = r_busy && !i_stall;
    assign at_last  = (r_kind == KIND_COMMENT);
    assign o_free   = !r_busy || (out_take && at_last);

    // Select the span being shown
    always_comb begin
        case (r_kind)
            KIND_NAME:    cur = r_set.name;
            KIND_EMAIL:   cur = r_set.email;
            KIND_COMMENT: cur = r_set.comment;
            default:      cur = '0;
        endcase
    end

    // Absent or empty parts read as zero
    always_comb begin
        o_valid       = r_busy;
        o_field_kind  = r_kind;
        o_span_start  = (cur.length != '0) ? SPAN_W'(cur.start) : '0;
        o_span_length = SPAN_W'(cur.length);
        o_overflow    = r_set.overflow;
        o_last_result = at_last;
    end

    // Walk name, email, comment; a new set loads as the last one leaves
    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        n_set  = r_set;
        if (i_load) begin
            n_busy = 1'b1;
            n_kind = KIND_NAME;
            n_set  = i_spans;
        end else if (out_take) begin
            case (r_kind)
                KIND_NAME:  n_kind = KIND_EMAIL;
                KIND_EMAIL: n_kind = KIND_COMMENT;
                default: begin
                    n_busy = 1'b0;
                    n_kind = KIND_NAME;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= KIND_NAME;
        end else begin
            r_busy <= n_busy;
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set <= n_set;
    end

endmodule

@@ rtl/user_id_field_splitter.sv @@
// A taken end marker shows its name span in the next cycle, then email and comment.
// Throughput: one byte request per cycle; an end marker gives three results, one per cycle
// while i_stall is low. An end marker waits only while the previous string's results drain;
// bytes of the next string are taken meanwhile.
// Reset: synchronous, active low; clears the parse state and empties the result register.
module user_id_field_splitter import uidfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_character,
    input  logic              i_end_of_string,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_field_kind,
    output logic [SPAN_W-1:0] o_span_start,
    output logic [SPAN_W-1:0] o_span_length,
    output logic              o_overflow,
    output logic              o_last_result
);

    t_span_set spans;
    logic      emit_free;
    logic      in_take;

    // Only an end marker has to wait for the result register
    assign o_stall = i_end_of_string && !emit_free;
    assign in_take = i_valid && !o_stall;

    uidfs_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (in_take),
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .o_spans         (spans)
    );

    uidfs_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_take && i_end_of_string),
        .i_spans       (spans),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_kind  (o_field_kind),
        .o_span_start  (o_span_start),
        .o_span_length (o_span_length),
        .o_overflow    (o_overflow),
        .o_last_result (o_last_result)
    );

endmodule
